// File: hw/rtl/spq_pkg.sv
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int PRIO_W        = 8;
  localparam int OCC_W         = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/sorted_priority_queue.sv
// Sorted priority queue, highest priority at the head.
// Input channel (in_valid / in_stall): mode selects insert or remove; an insert
// carries item_value and item_priority. A new entry goes behind every stored
// entry of equal or higher priority, so equal priorities leave in arrival order.
// Output channel (out_valid / out_stall): one result beat per input beat with
// status (ok, full, empty), the removed head_value / head_priority (zero unless
// a remove succeeds) and occupancy after the operation.
// Storage is a row of DEPTH cells; on insert every cell compares the new
// priority with its own and either holds, takes its left neighbor or takes the
// new entry; on remove every cell takes its right neighbor.
// The result is registered and appears in the cycle after the input beat is accepted.
// Throughput: one item per cycle while the receiver does not stall the output.
// Reset clears the entry count and out_valid; the queue is empty.
// While the receiver stalls with a result pending, in_stall is high and the
// result holds; a new beat is taken in the cycle the pending result leaves.
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 mode,
  input  logic signed [spq_pkg::VALUE_W-1:0]   item_value,
  input  logic        [spq_pkg::PRIO_W-1:0]    item_priority,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [1:0]                    status,
  output logic signed [spq_pkg::VALUE_W-1:0]   head_value,
  output logic        [spq_pkg::PRIO_W-1:0]    head_priority,
  output logic        [spq_pkg::OCC_W-1:0]     occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          full;
  logic          empty;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::status_t    status_next;

  logic signed [spq_pkg::VALUE_W-1:0] cell_value [DEPTH];
  logic        [spq_pkg::PRIO_W-1:0]  cell_prio  [DEPTH];
  logic                               cell_gt    [DEPTH];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);

  always_comb begin
    ctrl.ins    = 1'b0;
    ctrl.rem    = 1'b0;
    count_next  = count;
    status_next = spq_pkg::ST_OK;
    if (mode == spq_pkg::MODE_INSERT) begin
      if (full) begin
        status_next = spq_pkg::ST_FULL;
      end else begin
        ctrl.ins   = accept;
        count_next = count + CW'(1);
      end
    end else begin
      if (empty) begin
        status_next = spq_pkg::ST_EMPTY;
      end else begin
        ctrl.rem   = accept;
        count_next = count - CW'(1);
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                               prev_gt;
    logic signed [spq_pkg::VALUE_W-1:0] prev_value;
    logic        [spq_pkg::PRIO_W-1:0]  prev_prio;
    logic signed [spq_pkg::VALUE_W-1:0] next_value;
    logic        [spq_pkg::PRIO_W-1:0]  next_prio;

    if (i == 0) begin : g_first
      assign prev_gt    = 1'b0;
      assign prev_value = cell_value[0];
      assign prev_prio  = cell_prio[0];
    end else begin : g_mid
      assign prev_gt    = cell_gt[i-1];
      assign prev_value = cell_value[i-1];
      assign prev_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_value = cell_value[i];
      assign next_prio  = cell_prio[i];
    end else begin : g_inner
      assign next_value = cell_value[i+1];
      assign next_prio  = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (CW'(i) < count),
      .tail       (CW'(i) == count),
      .new_value  (item_value),
      .new_prio   (item_priority),
      .prev_gt    (prev_gt),
      .prev_value (prev_value),
      .prev_prio  (prev_prio),
      .next_value (next_value),
      .next_prio  (next_prio),
      .gt         (cell_gt[i]),
      .value      (cell_value[i]),
      .prio       (cell_prio[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      occupancy <= spq_pkg::OCC_W'(count_next);
      if (ctrl.rem) begin
        head_value    <= cell_value[0];
        head_priority <= cell_prio[0];
      end else begin
        head_value    <= '0;
        head_priority <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    accept && mode == spq_pkg::MODE_INSERT && full |=> $stable(count))
    else $error("rejected insert changed the entry count");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    count >= CW'(2) |-> cell_prio[0] >= cell_prio[1])
    else $error("head priority below second entry");

endmodule

// File: hw/rtl/spq_cell.sv
module spq_cell (
  input  logic                                   clk,
  input  spq_pkg::cell_ctrl_t                    ctrl,
  input  logic                                   occupied,
  input  logic                                   tail,
  input  logic signed [spq_pkg::VALUE_W-1:0]     new_value,
  input  logic        [spq_pkg::PRIO_W-1:0]      new_prio,
  input  logic                                   prev_gt,
  input  logic signed [spq_pkg::VALUE_W-1:0]     prev_value,
  input  logic        [spq_pkg::PRIO_W-1:0]      prev_prio,
  input  logic signed [spq_pkg::VALUE_W-1:0]     next_value,
  input  logic        [spq_pkg::PRIO_W-1:0]      next_prio,
  output logic                                   gt,
  output logic signed [spq_pkg::VALUE_W-1:0]     value,
  output logic        [spq_pkg::PRIO_W-1:0]      prio
);

  logic signed [spq_pkg::VALUE_W-1:0] value_next;
  logic        [spq_pkg::PRIO_W-1:0]  prio_next;

  assign gt = occupied && (new_prio > prio);

  always_comb begin
    value_next = value;
    prio_next  = prio;
    if (ctrl.ins) begin
      if (prev_gt) begin
        value_next = prev_value;
        prio_next  = prev_prio;
      end else if (gt || tail) begin
        value_next = new_value;
        prio_next  = new_prio;
      end
    end else if (ctrl.rem) begin
      value_next = next_value;
      prio_next  = next_prio;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    prio  <= prio_next;
  end

endmodule

// File: dv/sorted_priority_queue_test.sv
`timescale 1ns / 100ps

module sorted_priority_queue_test;

  localparam int QUEUE_DEPTH = spq_pkg::DEPTH_DEFAULT;

  typedef struct {
    spq_pkg::status_t                   st;
    logic signed [spq_pkg::VALUE_W-1:0] val;
    logic [spq_pkg::PRIO_W-1:0]         prio;
    logic [spq_pkg::OCC_W-1:0]          occ;
  } queue_result_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic                               mode = spq_pkg::MODE_INSERT;
  logic signed [spq_pkg::VALUE_W-1:0] item_value = '0;
  logic [spq_pkg::PRIO_W-1:0]         item_priority = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [1:0]                         status;
  logic signed [spq_pkg::VALUE_W-1:0] head_value;
  logic [spq_pkg::PRIO_W-1:0]         head_priority;
  logic [spq_pkg::OCC_W-1:0]          occupancy;

  logic signed [spq_pkg::VALUE_W-1:0] shadow_val[$];
  logic [spq_pkg::PRIO_W-1:0]         shadow_prio[$];
  queue_result_t                      pending_outcomes[$];
  int                                 error_count = 0;
  bit                                 no_gaps = 1'b0;
  int                                 hold_requests = 0;
  int                                 hold_served = 0;
  int                                 hold_cycles = 0;

  sorted_priority_queue dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .item_value(item_value),
    .item_priority(item_priority),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .head_value(head_value),
    .head_priority(head_priority),
    .occupancy(occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic queue_result_t apply_queue_op(
      input logic m,
      input logic signed [spq_pkg::VALUE_W-1:0] v,
      input logic [spq_pkg::PRIO_W-1:0] p);
    queue_result_t r;
    int pos;
    r.val = '0;
    r.prio = '0;
    if (m == spq_pkg::MODE_INSERT) begin
      if (shadow_prio.size() >= QUEUE_DEPTH) begin
        r.st = spq_pkg::ST_FULL;
      end else begin
        pos = shadow_prio.size();
        while (pos > 0 && p > shadow_prio[pos-1]) pos--;
        shadow_val.insert(pos, v);
        shadow_prio.insert(pos, p);
        r.st = spq_pkg::ST_OK;
      end
    end else if (shadow_prio.size() == 0) begin
      r.st = spq_pkg::ST_EMPTY;
    end else begin
      r.val = shadow_val.pop_front();
      r.prio = shadow_prio.pop_front();
      r.st = spq_pkg::ST_OK;
    end
    r.occ = spq_pkg::OCC_W'(shadow_prio.size());
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_op(input logic m, input logic signed [spq_pkg::VALUE_W-1:0] v,
                         input logic [spq_pkg::PRIO_W-1:0] p);
    while (!no_gaps && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    item_value <= v;
    item_priority <= p;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    @(posedge clk);
    pending_outcomes.push_back(apply_queue_op(m, v, p));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [spq_pkg::PRIO_W-1:0] pick_priority();
    case ($urandom_range(3))
      0: return spq_pkg::PRIO_W'($urandom);
      1: return spq_pkg::PRIO_W'($urandom_range(3));
      2: return $urandom_range(1) ? '1 : '0;
      default: return spq_pkg::PRIO_W'($urandom_range(110, 100));
    endcase
  endfunction

  task automatic send_random(input int count, input int insert_pct);
    logic m;
    repeat (count) begin
      m = ($urandom_range(99) < insert_pct) ? spq_pkg::MODE_INSERT : spq_pkg::MODE_REMOVE;
      send_op(m, $urandom, pick_priority());
    end
  endtask

  // flag each result beat at mid-cycle, ahead of the edge that takes it
  always @(negedge clk) begin
    queue_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d occ=%0d", status, occupancy));
      end else begin
        e = pending_outcomes.pop_front();
        if (status !== e.st)
          report_mismatch($sformatf("status %0d, want %0d", status, e.st));
        if (head_value !== e.val)
          report_mismatch($sformatf("head_value %0d, want %0d", head_value, e.val));
        if (head_priority !== e.prio)
          report_mismatch($sformatf("head_priority %0d, want %0d", head_priority, e.prio));
        if (occupancy !== e.occ)
          report_mismatch($sformatf("occupancy %0d, want %0d", occupancy, e.occ));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_requests != hold_served) begin
      out_stall <= 1'b1;
      hold_served <= hold_requests;
      hold_cycles <= 60;
    end else if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= !no_gaps && ($urandom_range(99) < 28);
    end
  end

  task automatic test_empty_remove();
    send_op(spq_pkg::MODE_REMOVE, $urandom, spq_pkg::PRIO_W'($urandom));
  endtask

  task automatic test_fill_and_overflow();
    logic [spq_pkg::PRIO_W-1:0] prio_list [16] = '{0, 255, 7, 7, 255, 0, 7, 128,
                                                  128, 1, 254, 7, 0, 255, 128, 3};
    logic signed [spq_pkg::VALUE_W-1:0] v;
    for (int i = 0; i < 16; i++) begin
      v = (i == 0) ? 32'sh8000_0000 : (i == 1) ? 32'sh7fff_ffff : $urandom;
      send_op(spq_pkg::MODE_INSERT, v, prio_list[i]);
    end
    send_op(spq_pkg::MODE_INSERT, 32'sh1234_5678, '1);
    repeat (6) send_op(spq_pkg::MODE_REMOVE, $urandom, spq_pkg::PRIO_W'($urandom));
  endtask

  task automatic test_random_traffic(input int count);
    int len;
    int pct;
    while (count > 0) begin
      len = $urandom_range(60, 10);
      case ($urandom_range(2))
        0: pct = 80;
        1: pct = 20;
        default: pct = 50;
      endcase
      send_random(len, pct);
      count -= len;
    end
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    send_random(150, 70);
    send_random(150, 30);
    no_gaps = 1'b0;
  endtask

  task automatic test_output_hold_off();
    hold_requests++;
    no_gaps = 1'b1;
    send_random(40, 60);
    no_gaps = 1'b0;
    send_random(60, 50);
  endtask

  task automatic test_sender_pause();
    send_random(50, 60);
    wait_drained();
    send_random(50, 40);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_remove();
    test_fill_and_overflow();
    test_random_traffic(600);
    test_back_to_back();
    test_output_hold_off();
    test_sender_pause();
    test_random_traffic(500);
    wait_drained();
    repeat (4) @(posedge clk);
    if (error_count == 0)
      $display("sorted_priority_queue test passed");
    else
      $display("sorted_priority_queue test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("sorted_priority_queue test failed");
    $finish;
  end

endmodule
